/* hw/rtl/pvp_pkg.sv */
package pvp_pkg;

    localparam int unsigned DIV_STEPS = 25;
    localparam int unsigned DVD_W     = 30;
    localparam int unsigned DEPTH_W   = 18;

    typedef enum logic [7:0] {
        REG_CAM_X   = 8'd0,
        REG_CAM_Y   = 8'd1,
        REG_CAM_Z   = 8'd2,
        REG_YAW     = 8'd3,
        REG_PITCH   = 8'd4,
        REG_FOCAL   = 8'd5,
        REG_WIDTH   = 8'd6,
        REG_HEIGHT  = 8'd7
    } reg_index_t;

    typedef struct packed {
        logic                 visible;
        logic                 neg_x;
        logic                 neg_y;
        logic [DEPTH_W-1:0]   depth;
        logic [DEPTH_W-1:0]   rem_x;
        logic [DEPTH_W-1:0]   rem_y;
        logic [DVD_W-1:0]     dvd_x;
        logic [DVD_W-1:0]     dvd_y;
    } div_stage_t;

    // triangle wave: p or 255-p, times 16, minus 1024
    function automatic logic signed [10:0] tri_wave(input logic [7:0] p);
        logic [6:0]  v;
        logic [11:0] t;
        begin
            v = p[7] ? ~p[6:0] : p[6:0];
            t = {1'b0, v, 4'b0000} - 12'd1024;
            return signed'(t[10:0]);
        end
    endfunction

    // divide by 1024, truncating toward zero
    function automatic logic signed [20:0] div1024(input logic signed [30:0] a);
        logic signed [30:0] t;
        begin
            t = a + (a[30] ? 31'sd1023 : 31'sd0);
            return t[30:10];
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [26:0] v);
        begin
            if (v < -27'sd32768)
                return 16'sh8000;
            else if (v > 27'sd32767)
                return 16'sh7fff;
            else
                return v[15:0];
        end
    endfunction

endpackage

/* hw/rtl/perspective_vertex_projector.sv */
// the input request passes through 6 transform stages, 1 divider setup stage,
// 25 restoring divider stages and 1 output register before the result is valid
// throughput: one vertex per cycle while the skid register is empty; the quotient comes one bit per stage
// a held output parks one result in the skid register and stalls the input
// rst_n clears all valid bits and loads the register reset values
// (camera 0, yaw 0, pitch 0, focal 220, width 640, height 480)
module perspective_vertex_projector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // vertex_x, vertex_y, vertex_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // screen_x, screen_y, view_depth, zero pad
    output logic [0:0]  m_tuser    // visible
);

    localparam int unsigned NS = pvp_pkg::DIV_STEPS;

    logic signed [15:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [7:0]         yaw_reg, pitch_reg;
    logic [11:0]        focal_reg, width_reg, height_reg;

    logic signed [10:0] ys, yc, ps, pc;

    logic               adv;

    logic               v1_reg;
    logic signed [16:0] x1s_reg, y1s_reg, z1s_reg;
    logic               v2_reg;
    logic signed [27:0] pxc_reg, pzs_reg, pxs_reg, pzc_reg;
    logic signed [16:0] y2s_reg;
    logic               v3_reg;
    logic signed [17:0] rx_reg, rz_reg;
    logic signed [16:0] y3s_reg;
    logic               v4_reg;
    logic signed [17:0] rx4_reg;
    logic signed [28:0] pyc_reg, pzps_reg, pys_reg, pzpc_reg;
    logic               v5_reg;
    logic signed [17:0] rx5_reg;
    logic signed [18:0] ry_reg;
    logic signed [19:0] z2_reg;
    logic               v6_reg;
    logic               vis6_reg;
    logic [17:0]        d6_reg;
    logic signed [30:0] fx_reg;
    logic signed [31:0] fy_reg;

    pvp_pkg::div_stage_t div_reg [0:NS];
    pvp_pkg::div_stage_t div_next [1:NS];
    logic [NS:0]         dv_reg;

    logic signed [29:0] sum3a, sum3b;
    logic signed [29:0] sum5a, sum5b;
    logic signed [20:0] q3a, q3b, q5a, q5b;
    logic signed [19:0] z2_next;
    logic [30:0]        abs_x;
    logic [31:0]        abs_y;

    logic [55:0] fin_data;
    logic        fin_vis;
    logic [24:0] qx, qy;
    logic signed [26:0] sqx, sqy, scx, scy;
    logic signed [15:0] sx, sy;

    logic [55:0] out_data_reg, skid_data_reg;
    logic        out_vis_reg, skid_vis_reg;
    logic        out_valid_reg, skid_valid_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg  <= '0;
            cam_y_reg  <= '0;
            cam_z_reg  <= '0;
            yaw_reg    <= '0;
            pitch_reg  <= '0;
            focal_reg  <= 12'd220;
            width_reg  <= 12'd640;
            height_reg <= 12'd480;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pvp_pkg::REG_CAM_X:  cam_x_reg  <= signed'(cfg_data);
                pvp_pkg::REG_CAM_Y:  cam_y_reg  <= signed'(cfg_data);
                pvp_pkg::REG_CAM_Z:  cam_z_reg  <= signed'(cfg_data);
                pvp_pkg::REG_YAW:    yaw_reg    <= cfg_data[7:0];
                pvp_pkg::REG_PITCH:  pitch_reg  <= cfg_data[7:0];
                pvp_pkg::REG_FOCAL:  focal_reg  <= cfg_data[11:0];
                pvp_pkg::REG_WIDTH:  width_reg  <= cfg_data[11:0];
                pvp_pkg::REG_HEIGHT: height_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign ys = pvp_pkg::tri_wave(yaw_reg);
    assign yc = pvp_pkg::tri_wave(yaw_reg + 8'd64);
    assign ps = pvp_pkg::tri_wave(pitch_reg);
    assign pc = pvp_pkg::tri_wave(pitch_reg + 8'd64);

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    // transform arithmetic
    always_comb
    begin
        sum3a   = 30'(pxc_reg) - 30'(pzs_reg);
        sum3b   = 30'(pxs_reg) + 30'(pzc_reg);
        q3a     = pvp_pkg::div1024(31'(sum3a));
        q3b     = pvp_pkg::div1024(31'(sum3b));
        sum5a   = 30'(pyc_reg) - 30'(pzps_reg);
        sum5b   = 30'(pys_reg) + 30'(pzpc_reg);
        q5a     = pvp_pkg::div1024(31'(sum5a));
        q5b     = pvp_pkg::div1024(31'(sum5b));
        z2_next = q5b[19:0] + 20'sd384;
        abs_x   = fx_reg[30] ? 31'(-fx_reg) : 31'(fx_reg);
        abs_y   = fy_reg[31] ? 32'(-fy_reg) : 32'(fy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            dv_reg <= '0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            dv_reg <= {dv_reg[NS-1:0], v6_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1s_reg <= 17'(signed'(s_tdata[15:0]))  - 17'(cam_x_reg);
            y1s_reg <= 17'(signed'(s_tdata[31:16])) - 17'(cam_y_reg);
            z1s_reg <= 17'(signed'(s_tdata[47:32])) - 17'(cam_z_reg);

            pxc_reg <= 28'(x1s_reg * yc);
            pzs_reg <= 28'(z1s_reg * ys);
            pxs_reg <= 28'(x1s_reg * ys);
            pzc_reg <= 28'(z1s_reg * yc);
            y2s_reg <= y1s_reg;

            rx_reg  <= q3a[17:0];
            rz_reg  <= q3b[17:0];
            y3s_reg <= y2s_reg;

            rx4_reg  <= rx_reg;
            pyc_reg  <= 29'(y3s_reg * pc);
            pzps_reg <= 29'(rz_reg * ps);
            pys_reg  <= 29'(y3s_reg * ps);
            pzpc_reg <= 29'(rz_reg * pc);

            rx5_reg <= rx4_reg;
            ry_reg  <= q5a[18:0];
            z2_reg  <= z2_next;

            vis6_reg <= (z2_reg >= 20'sd48);
            d6_reg   <= (z2_reg >= 20'sd48) ? z2_reg[17:0] : 18'd48;
            fx_reg   <= 31'(rx5_reg * signed'({1'b0, focal_reg}));
            fy_reg   <= 32'(ry_reg * signed'({1'b0, focal_reg}));

            div_reg[0].visible <= vis6_reg;
            div_reg[0].neg_x   <= fx_reg[30];
            div_reg[0].neg_y   <= fy_reg[31];
            div_reg[0].depth   <= d6_reg;
            div_reg[0].rem_x   <= 18'(abs_x[29:25]);
            div_reg[0].rem_y   <= 18'(abs_y[29:25]);
            div_reg[0].dvd_x   <= {abs_x[24:0], 5'b00000};
            div_reg[0].dvd_y   <= {abs_y[24:0], 5'b00000};

            for (int i = 1; i <= NS; i++)
            begin
                div_reg[i] <= div_next[i];
            end
        end
    end

    // restoring divider, one quotient bit per stage
    always_comb
    begin
        for (int i = 1; i <= NS; i++)
        begin
            logic [18:0] tx, ty;
            logic        gx, gy;
            tx = {div_reg[i-1].rem_x, div_reg[i-1].dvd_x[29]};
            ty = {div_reg[i-1].rem_y, div_reg[i-1].dvd_y[29]};
            gx = (tx >= {1'b0, div_reg[i-1].depth});
            gy = (ty >= {1'b0, div_reg[i-1].depth});
            div_next[i]       = div_reg[i-1];
            div_next[i].rem_x = gx ? 18'(tx - {1'b0, div_reg[i-1].depth}) : tx[17:0];
            div_next[i].rem_y = gy ? 18'(ty - {1'b0, div_reg[i-1].depth}) : ty[17:0];
            div_next[i].dvd_x = {div_reg[i-1].dvd_x[28:0], gx};
            div_next[i].dvd_y = {div_reg[i-1].dvd_y[28:0], gy};
        end
    end

    // centre offset, sign and saturation
    always_comb
    begin
        qx  = div_reg[NS].dvd_x[24:0];
        qy  = div_reg[NS].dvd_y[24:0];
        sqx = div_reg[NS].neg_x ? -signed'({2'b00, qx}) : signed'({2'b00, qx});
        sqy = div_reg[NS].neg_y ? -signed'({2'b00, qy}) : signed'({2'b00, qy});
        scx = signed'(27'(width_reg[11:1]))  + sqx;
        scy = signed'(27'(height_reg[11:1])) - sqy;
        sx  = pvp_pkg::sat16(scx);
        sy  = pvp_pkg::sat16(scy);
        fin_vis = div_reg[NS].visible;
        if (fin_vis)
            fin_data = {6'b0, div_reg[NS].depth, sy, sx};
        else
            fin_data = '0;
    end

    // output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg  <= skid_valid_reg || (adv && dv_reg[NS]);
            skid_valid_reg <= 1'b0;
        end
        else if (adv && dv_reg[NS])
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : fin_data;
            out_vis_reg  <= skid_valid_reg ? skid_vis_reg  : fin_vis;
        end
        else if (adv && dv_reg[NS])
        begin
            skid_data_reg <= fin_data;
            skid_vis_reg  <= fin_vis;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_vis_reg;

endmodule
